// File: hdl/mpq_pkg.sv
// Shared types and codes for the min priority queue.
// Used by the entry store, the top level and the testbench.
`timescale 1ns / 1ps

package mpq_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_SET  = 2'd2,
        REQ_NOP  = 2'd3
    } req_type_e_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_POP_ROOT,
        S_RD_LAST,
        S_LOAD,
        S_SCAN,
        S_D_CHK,
        S_D_L,
        S_D_R,
        S_D_DEC,
        S_U_CHK,
        S_U_CMP,
        S_FIN
    } state_t;

    // One heap slot: priority key and the value it carries.
    typedef struct packed {
        logic signed [31:0] prio;
        logic signed [31:0] value;
    } entry_t;

endpackage

// File: hdl/mpq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing but the field widths fixed for the block.
`timescale 1ns / 1ps

interface mpq_req_if;
    logic              valid;
    logic              ready;
    logic        [1:0] req_type;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;

    modport source (output valid, req_type, item_value, item_priority, input ready);
    modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface mpq_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] popped_value;
    logic        [1:0] status;
    logic        [7:0] entry_count;
    logic              is_empty;

    modport source (output valid, popped_value, status, entry_count, is_empty, input ready);
    modport sink   (input valid, popped_value, status, entry_count, is_empty, output ready);
endinterface

// File: hdl/mpq_store.sv
// Heap slot memory: one write port, one read port, registered read data.
// Depends on mpq_pkg for the slot type.
`timescale 1ns / 1ps

module mpq_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output mpq_pkg::entry_t rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  mpq_pkg::entry_t wr_data
);
    import mpq_pkg::*;

    entry_t entry_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/min_priority_queue.sv
// Min priority queue: a binary min-heap of value/priority pairs kept in one slot
// memory, lowest priority on top. One request is handled at a time; a new request
// is taken while the previous response still waits. A push sifts the new entry up;
// a pop moves the last entry to the root and sifts it down; set priority scans for
// the value, removes the first match and re-inserts it with the new priority, or
// pushes it as a new entry if none matches and there is room. Reset clears the
// entry count and the control state; slots need no clearing.
`timescale 1ns / 1ps

module min_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    mpq_req_if.sink    req,
    mpq_rsp_if.source  rsp
);
    import mpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      start_reg, start_next;
    entry_t             mv_reg, mv_next;
    entry_t             left_reg, left_next;
    entry_t             right_reg, right_next;
    logic               r_ok_reg, r_ok_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic               up_after_reg, up_after_next;
    logic               push_pend_reg, push_pend_next;
    status_t            status_reg, status_next;
    logic signed [31:0] popped_reg, popped_next;
    req_type_e_t        type_reg, type_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] p_reg, p_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic signed [31:0] rsp_popped_reg, rsp_popped_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic [7:0]         rsp_count_reg, rsp_count_next;
    logic               rsp_empty_reg, rsp_empty_next;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    entry_t             rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;

    logic               in_ready;
    logic               down_stop;
    logic               up_stop;
    logic               sift_end;
    logic [XW-1:0]      left_w;
    logic [XW-1:0]      right_w;
    logic [XW-1:0]      count_w;
    logic [CW-1:0]      count_m1;
    logic [AW-1:0]      pos_m1;
    logic [AW-1:0]      parent;
    entry_t             cand;
    logic [AW-1:0]      cand_idx;
    logic               cand_is_mv;

    mpq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign left_w   = {1'b0, pos_reg, 1'b1};
    assign right_w  = left_w + XW'(1);
    assign count_w  = XW'(count_reg);
    assign count_m1 = count_reg - CW'(1);
    assign pos_m1   = pos_reg - AW'(1);
    assign parent   = pos_m1 >> 1;

    // Smallest of the moving entry and its children; it, then left, wins ties.
    always_comb
    begin
        cand       = mv_reg;
        cand_idx   = pos_reg;
        cand_is_mv = 1'b1;
        if (mv_reg.prio > left_reg.prio)
        begin
            cand       = left_reg;
            cand_idx   = left_w[AW-1:0];
            cand_is_mv = 1'b0;
        end
        if (r_ok_reg && (cand.prio > right_reg.prio))
        begin
            cand       = right_reg;
            cand_idx   = right_w[AW-1:0];
            cand_is_mv = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            up_after_reg  <= 1'b0;
            push_pend_reg <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            up_after_reg  <= up_after_next;
            push_pend_reg <= push_pend_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        start_reg      <= start_next;
        mv_reg         <= mv_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        r_ok_reg       <= r_ok_next;
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        status_reg     <= status_next;
        popped_reg     <= popped_next;
        type_reg       <= type_next;
        v_reg          <= v_next;
        p_reg          <= p_next;
        rsp_popped_reg <= rsp_popped_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_empty_reg  <= rsp_empty_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        start_next      = start_reg;
        mv_next         = mv_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        r_ok_next       = r_ok_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        up_after_next   = up_after_reg;
        push_pend_next  = push_pend_reg;
        status_next     = status_reg;
        popped_next     = popped_reg;
        type_next       = type_reg;
        v_next          = v_reg;
        p_next          = p_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_popped_next = rsp_popped_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_empty_next  = rsp_empty_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = mv_reg;
        in_ready        = 1'b0;
        down_stop       = 1'b0;
        up_stop         = 1'b0;
        sift_end        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (req.valid)
                begin
                    type_next      = req_type_e_t'(req.req_type);
                    v_next         = req.item_value;
                    p_next         = req.item_priority;
                    popped_next    = '0;
                    status_next    = ST_OK;
                    push_pend_next = 1'b0;
                    up_after_next  = 1'b0;
                    case (req_type_e_t'(req.req_type))
                        REQ_PUSH:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_POP_ROOT;
                            end
                        end
                        REQ_SET:
                        begin
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                mv_next.prio  = p_reg;
                mv_next.value = v_reg;
                pos_next      = count_reg[AW-1:0];
                count_next    = count_reg + CW'(1);
                state_next    = S_U_CHK;
            end

            S_POP_ROOT:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_RD_LAST;
            end

            S_RD_LAST:
            begin
                // on a pop, read data here is the root
                if (type_reg == REQ_POP)
                begin
                    popped_next = rd_data.value;
                    pos_next    = '0;
                end
                rd_en      = 1'b1;
                rd_addr    = count_m1[AW-1:0];
                count_next = count_m1;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                mv_next    = rd_data;
                state_next = S_D_CHK;
            end

            S_SCAN:
            begin
                // reads issued one per cycle, compare works on the registered read data
                if (pend_reg && (rd_data.value == v_reg))
                begin
                    pend_next   = 1'b0;
                    status_next = ST_OK;
                    if (CW'(pend_idx_reg) < count_m1)
                    begin
                        pos_next       = pend_idx_reg;
                        start_next     = pend_idx_reg;
                        up_after_next  = 1'b1;
                        push_pend_next = 1'b1;
                        state_next     = S_RD_LAST;
                    end
                    else
                    begin
                        count_next = count_m1;
                        state_next = S_PUSH;
                    end
                end
                else if (!pend_reg && (scan_reg >= count_reg))
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_PUSH;
                    end
                end
                else if (scan_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_reg[AW-1:0];
                    scan_next     = scan_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            S_D_CHK:
            begin
                if (left_w >= count_w)
                begin
                    down_stop = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = left_w[AW-1:0];
                    state_next = S_D_L;
                end
            end

            S_D_L:
            begin
                left_next = rd_data;
                if (right_w < count_w)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = right_w[AW-1:0];
                    r_ok_next  = 1'b1;
                    state_next = S_D_R;
                end
                else
                begin
                    r_ok_next  = 1'b0;
                    state_next = S_D_DEC;
                end
            end

            S_D_R:
            begin
                right_next = rd_data;
                state_next = S_D_DEC;
            end

            S_D_DEC:
            begin
                if (cand_is_mv)
                begin
                    down_stop = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = cand;
                    pos_next   = cand_idx;
                    state_next = S_D_CHK;
                end
            end

            S_U_CHK:
            begin
                if (pos_reg == '0)
                begin
                    up_stop = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_U_CMP;
                end
            end

            S_U_CMP:
            begin
                if (rd_data.prio > mv_reg.prio)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = S_U_CHK;
                end
                else
                begin
                    up_stop = 1'b1;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_popped_next = popped_reg;
                    rsp_status_next = status_reg;
                    rsp_count_next  = 8'(count_reg);
                    rsp_empty_next  = (count_reg == '0);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // removal entry that did not move down may still need to move up
        if (down_stop)
        begin
            up_after_next = 1'b0;
            if (up_after_reg && (pos_reg == start_reg))
            begin
                state_next = S_U_CHK;
            end
            else
            begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg;
                wr_data  = mv_reg;
                sift_end = 1'b1;
            end
        end

        if (up_stop)
        begin
            wr_en    = 1'b1;
            wr_addr  = pos_reg;
            wr_data  = mv_reg;
            sift_end = 1'b1;
        end

        if (sift_end)
        begin
            if (push_pend_reg)
            begin
                push_pend_next = 1'b0;
                state_next     = S_PUSH;
            end
            else
            begin
                state_next = S_FIN;
            end
        end
    end

    assign req.ready        = in_ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.popped_value = rsp_popped_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.entry_count  = rsp_count_reg;
    assign rsp.is_empty     = rsp_empty_reg;

    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY)
    ) else $error("entry count above capacity");

    a_full_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && status_reg == ST_FULL) |-> (count_reg == CW'(CAPACITY))
    ) else $error("full status with room left");

    a_empty_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.popped_value == '0 && rsp.is_empty)
    ) else $error("empty pop response carries data or entries");

    a_write_in_heap: assert property (
        @(posedge clk) disable iff (!rst_n)
        (wr_en && count_reg != '0) |-> (CW'(wr_addr) < count_reg)
    ) else $error("slot write beyond the heap");

endmodule

// File: bench/tb_min_priority_queue.sv
// Testbench for min_priority_queue: directed table, then random push/pop/set/nop traffic.
// Responses are checked against a shadow heap kept here, or the table's typed response. Uses mpq_pkg and mpq_if.
`timescale 1ns / 1ps

module tb_min_priority_queue;
    import mpq_pkg::*;

    localparam int HEAP_SLOTS     = 128;
    localparam int RAND_PER_PHASE = 610;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 64;
    localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] P_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] popped;
        status_t            status;
        logic        [7:0]  count;
        logic               empty;
    } queue_rsp_t;

    typedef struct {
        req_type_e_t        req;
        logic signed [31:0] value;
        logic signed [31:0] prio;
        bit                 typed;
        queue_rsp_t         rsp;
    } plan_row_t;

    logic clk;
    logic rst_n;

    mpq_req_if req_ch ();
    mpq_rsp_if rsp_ch ();

    min_priority_queue #(
        .CAPACITY(HEAP_SLOTS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // shadow copy of the heap
    logic signed [31:0] shadow_val [HEAP_SLOTS];
    logic signed [31:0] shadow_pri [HEAP_SLOTS];
    int                 shadow_n;

    queue_rsp_t pending_rsp [$];
    plan_row_t  plan [$];
    int         err_count;
    int         rsp_seen;
    int         phase;
    int         send_idle;
    int         recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void exchange_slots(int a, int b);
        logic signed [31:0] t;
        t = shadow_val[a];
        shadow_val[a] = shadow_val[b];
        shadow_val[b] = t;
        t = shadow_pri[a];
        shadow_pri[a] = shadow_pri[b];
        shadow_pri[b] = t;
    endfunction

    function automatic void sift_up(int pos);
        int par;
        while (pos > 0)
        begin
            par = (pos - 1) / 2;
            if (shadow_pri[par] <= shadow_pri[pos])
                break;
            exchange_slots(par, pos);
            pos = par;
        end
    endfunction

    // left child wins ties; swap only on a strictly smaller child
    function automatic void sift_down(int pos);
        int best;
        int lc;
        int rc;
        while (pos < shadow_n)
        begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < shadow_n && shadow_pri[best] > shadow_pri[lc])
                best = lc;
            if (rc < shadow_n && shadow_pri[best] > shadow_pri[rc])
                best = rc;
            if (best == pos)
                break;
            exchange_slots(pos, best);
            pos = best;
        end
    endfunction

    function automatic bit heap_insert(logic signed [31:0] v, logic signed [31:0] p);
        if (shadow_n >= HEAP_SLOTS)
            return 1'b0;
        shadow_val[shadow_n] = v;
        shadow_pri[shadow_n] = p;
        shadow_n++;
        sift_up(shadow_n - 1);
        return 1'b1;
    endfunction

    // Applies one request to the shadow heap and returns the response it yields.
    function automatic queue_rsp_t apply_request(req_type_e_t req, logic signed [31:0] v,
                                                 logic signed [31:0] p);
        queue_rsp_t r;
        int         idx;
        bit         hit;
        r.popped = '0;
        r.status = ST_OK;
        case (req)
            REQ_PUSH:
            begin
                if (!heap_insert(v, p))
                    r.status = ST_FULL;
            end
            REQ_POP:
            begin
                if (shadow_n == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped = shadow_val[0];
                    shadow_n--;
                    shadow_val[0] = shadow_val[shadow_n];
                    shadow_pri[0] = shadow_pri[shadow_n];
                    sift_down(0);
                end
            end
            REQ_SET:
            begin
                hit = 1'b0;
                idx = 0;
                while (idx < shadow_n && !hit)
                begin
                    if (shadow_val[idx] == v)
                        hit = 1'b1;
                    else
                        idx++;
                end
                if (hit)
                begin
                    shadow_n--;
                    // last slot removed: nothing to move
                    if (idx < shadow_n)
                    begin
                        shadow_val[idx] = shadow_val[shadow_n];
                        shadow_pri[idx] = shadow_pri[shadow_n];
                        sift_down(idx);
                        sift_up(idx);
                    end
                    void'(heap_insert(v, p));
                end
                else if (heap_insert(v, p))
                    r.status = ST_NOT_FOUND;
                else
                    r.status = ST_FULL;
            end
            default: ;
        endcase
        r.count = shadow_n[7:0];
        r.empty = (shadow_n == 0);
        return r;
    endfunction

    task automatic add_row(req_type_e_t req, logic signed [31:0] v, logic signed [31:0] p,
                           bit typed, logic signed [31:0] pv, status_t st, logic [7:0] cnt);
        plan_row_t row;
        row.req = req;
        row.value = v;
        row.prio = p;
        row.typed = typed;
        row.rsp.popped = pv;
        row.rsp.status = st;
        row.rsp.count = cnt;
        row.rsp.empty = (cnt == 0);
        plan.push_back(row);
    endtask

    // Offers one request, waits for the transfer, then records its response.
    task automatic send_request(req_type_e_t req, logic signed [31:0] v,
                                logic signed [31:0] p, bit typed, queue_rsp_t typed_rsp);
        queue_rsp_t computed;
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= req;
        req_ch.item_value    <= v;
        req_ch.item_priority <= p;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        computed = apply_request(req, v, p);
        pending_rsp.push_back(typed ? typed_rsp : computed);
    endtask

    // stimulus
    initial
    begin
        req_type_e_t        req;
        logic signed [31:0] v;
        logic signed [31:0] p;
        int                 r;
        int                 sel;
        bit                 draining;

        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_PUSH;
        req_ch.item_value    <= '0;
        req_ch.item_priority <= '0;
        shadow_n  = 0;
        err_count = 0;
        phase     = 0;
        send_idle = 24;
        recv_idle = 69;
        draining  = 1'b0;

        add_row(REQ_POP,  0,     0,     1, 0, ST_EMPTY,     0);
        add_row(REQ_NOP,  -1,    -1,    1, 0, ST_OK,        0);
        add_row(REQ_SET,  7,     5,     1, 0, ST_NOT_FOUND, 1);
        add_row(REQ_PUSH, P_MIN, P_MAX, 1, 0, ST_OK,        2);
        add_row(REQ_PUSH, P_MAX, P_MIN, 1, 0, ST_OK,        3);
        add_row(REQ_PUSH, 0,     0,     1, 0, ST_OK,        4);
        add_row(REQ_PUSH, -1,    -1,    1, 0, ST_OK,        5);
        // ties the root: must not climb past it
        add_row(REQ_PUSH, 3,     P_MIN, 1, 0, ST_OK,        6);
        add_row(REQ_POP,  0,     0,     1, P_MAX, ST_OK,    5);
        add_row(REQ_POP,  0,     0,     0, 0, ST_OK,        0);
        add_row(REQ_SET,  0,     P_MIN, 0, 0, ST_OK,        0);
        add_row(REQ_SET,  P_MIN, -5,    0, 0, ST_OK,        0);
        add_row(REQ_SET,  99,    1,     1, 0, ST_NOT_FOUND, 5);
        // duplicate value: set hits the first one in slot order
        add_row(REQ_PUSH, 7,     2,     0, 0, ST_OK,        0);
        add_row(REQ_SET,  7,     100,   0, 0, ST_OK,        0);
        add_row(REQ_NOP,  7,     P_MIN, 1, 0, ST_OK,        6);
        repeat (6)
            add_row(REQ_POP, 0, 0, 0, 0, ST_OK, 0);
        add_row(REQ_POP,  0,     0,     1, 0, ST_EMPTY,     0);
        add_row(REQ_PUSH, 32'sh5555_5555, 32'shaaaa_aaaa, 1, 0, ST_OK, 1);
        add_row(REQ_POP,  0,     0,     1, 32'sh5555_5555, ST_OK, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].req, plan[i].value, plan[i].prio, plan[i].typed,
                         plan[i].rsp);

        // fill to capacity, push past it, drain to empty, pop past it; repeat
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 24 : (phase == 1) ? 69 : 0;
            recv_idle = (phase == 0) ? 69 : (phase == 1) ? 24 : 0;
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                if (!draining && shadow_n == HEAP_SLOTS && $urandom_range(0, 3) == 0)
                    draining = 1'b1;
                else if (draining && shadow_n == 0 && $urandom_range(0, 2) == 0)
                    draining = 1'b0;

                r = $urandom_range(0, 99);
                if (r < 65)
                    req = draining ? REQ_POP : REQ_PUSH;
                else if (r < 82)
                    req = REQ_SET;
                else if (r < 94)
                    req = draining ? REQ_PUSH : REQ_POP;
                else
                    req = REQ_NOP;

                // small value pool so set finds matches and duplicates
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    v = $urandom_range(0, 15);
                else if (sel < 8)
                    v = -$urandom_range(1, 8);
                else
                    v = $urandom;

                sel = $urandom_range(0, 9);
                if (sel < 4)
                    p = $urandom_range(0, 16) - 8;
                else if (sel < 8)
                    p = $urandom;
                else
                begin
                    case ($urandom_range(0, 3))
                        0: p = P_MIN;
                        1: p = P_MAX;
                        2: p = 0;
                        default: p = -1;
                    endcase
                end

                send_request(req, v, p, 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // response side: random stalls, one long hold-off, checks each transfer
    initial
    begin
        queue_rsp_t want;
        int         hold_left;
        bit         hold_done;

        rsp_ch.ready <= 1'b0;
        rsp_seen  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen++;
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: response with nothing outstanding, got status %0d",
                             $time, rsp_ch.status);
                    err_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_ch.popped_value !== want.popped)
                    begin
                        $display("%0t: popped_value expected %0d got %0d",
                                 $time, want.popped, rsp_ch.popped_value);
                        err_count++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp_ch.status);
                        err_count++;
                    end
                    if (rsp_ch.entry_count !== want.count)
                    begin
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, want.count, rsp_ch.entry_count);
                        err_count++;
                    end
                    if (rsp_ch.is_empty !== want.empty)
                    begin
                        $display("%0t: is_empty expected %0d got %0d",
                                 $time, want.empty, rsp_ch.is_empty);
                        err_count++;
                    end
                end
            end

            if (!hold_done && phase == 2 && rsp_seen >= 1500)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // watchdog: too long without any transfer on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                         $time, quiet, pending_rsp.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

// File: min_priority_queue.f
hdl/mpq_pkg.sv
hdl/mpq_if.sv
hdl/mpq_store.sv
hdl/min_priority_queue.sv
bench/tb_min_priority_queue.sv
